@@ src/sscd_pkg.sv @@
// Shared types, constants and saturation helpers for the stereo soft-clip
// distortion block. No dependencies; used by every other file in src.
`default_nettype none
package sscd_pkg;

	// Sample and coefficient formats
	localparam int SAMPLE_WIDTH = 24;
	localparam int COEF_WIDTH   = 24;
	localparam int FRAC_BITS    = SAMPLE_WIDTH - 1;
	localparam int COEF_FRAC    = COEF_WIDTH - 2;
	localparam int STATE_W      = 32;
	localparam int DRIVE_W      = 24;
	localparam int MAKEUP_W     = 18;
	localparam int MIX_W        = 17;
	localparam int GAIN_FRAC    = 16;

	// Stream and configuration port widths
	localparam int TDATA_W  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int CFG_W    = (COEF_WIDTH > DRIVE_W) ? COEF_WIDTH : DRIVE_W;
	localparam int CFG_IDX_W = 3;

	// Shared multiplier operand and product widths
	localparam int MA_W   = (SAMPLE_WIDTH + 1 > STATE_W) ? SAMPLE_WIDTH + 1 : STATE_W;
	localparam int MB_T   = (SAMPLE_WIDTH + 1 > DRIVE_W + 1) ? SAMPLE_WIDTH + 1 : DRIVE_W + 1;
	localparam int MB_W   = (COEF_WIDTH > MB_T) ? COEF_WIDTH : MB_T;
	localparam int PROD_W = MA_W + MB_W;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_B0     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_B1     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_B2     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_A1     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_A2     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MAKEUP = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_MIX    = 3'd7;

	// Reset values and fixed numbers
	localparam logic [DRIVE_W-1:0]    DRIVE_RST  = DRIVE_W'(65536);
	localparam logic [COEF_WIDTH-1:0] B0_RST     = COEF_WIDTH'(64'd1 << COEF_FRAC);
	localparam logic [MAKEUP_W-1:0]   MAKEUP_RST = MAKEUP_W'(65536);
	localparam logic [MIX_W-1:0]      MIX_RST    = MIX_W'(32768);
	localparam logic [MIX_W-1:0]      MIX_ONE    = MIX_W'(65536);

	// Clipper: unity, clip limit 2/3 and a reciprocal of three for the cube term
	localparam logic signed [PROD_W-1:0] ONE_P = PROD_W'(64'sd1 <<< FRAC_BITS);
	localparam logic signed [PROD_W-1:0] NEG_ONE_P = -ONE_P;
	localparam logic signed [SAMPLE_WIDTH:0] CLIP_LIM =
		(SAMPLE_WIDTH + 1)'((64'd1 << (FRAC_BITS + 1)) / 64'd3);
	localparam logic [SAMPLE_WIDTH-1:0] RECIP3 =
		SAMPLE_WIDTH'(((64'd1 << (SAMPLE_WIDTH + 1)) + 64'd2) / 64'd3);

	// Saturation bounds
	localparam logic signed [PROD_W-1:0] ST_HI  = PROD_W'((64'sd1 <<< (STATE_W - 1)) - 64'sd1);
	localparam logic signed [PROD_W-1:0] ST_LO  = -ST_HI - PROD_W'(1);
	localparam logic signed [PROD_W-1:0] SMP_HI =
		PROD_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [PROD_W-1:0] SMP_LO = -SMP_HI - PROD_W'(1);

	// Datapath micro-operations, one multiply each
	typedef enum logic [3:0] {
		OP_DRIVE  = 4'd0,
		OP_SQ     = 4'd1,
		OP_CUBE   = 4'd2,
		OP_DIV3   = 4'd3,
		OP_B0     = 4'd4,
		OP_B1     = 4'd5,
		OP_A1     = 4'd6,
		OP_B2     = 4'd7,
		OP_A2     = 4'd8,
		OP_MAKEUP = 4'd9,
		OP_DRY    = 4'd10,
		OP_WET    = 4'd11
	} op_t;

	localparam op_t OP_LAST = OP_WET;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic mul_en;
		logic acc_en;
		logic push;
		op_t  op;
		logic ch;
	} dp_cmd_t;

	function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [PROD_W-1:0] v);
		logic signed [STATE_W-1:0] r;
		if (v > ST_HI) begin
			r = ST_HI[STATE_W-1:0];
		end else if (v < ST_LO) begin
			r = ST_LO[STATE_W-1:0];
		end else begin
			r = v[STATE_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
		input logic signed [PROD_W-1:0] v);
		logic signed [SAMPLE_WIDTH-1:0] r;
		if (v > SMP_HI) begin
			r = SMP_HI[SAMPLE_WIDTH-1:0];
		end else if (v < SMP_LO) begin
			r = SMP_LO[SAMPLE_WIDTH-1:0];
		end else begin
			r = v[SAMPLE_WIDTH-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ src/sscd_ctrl.sv @@
// Sequencer for the stereo soft-clip block: walks each channel through the
// multiply/accumulate steps and runs both stream handshakes. Uses sscd_pkg.
`default_nettype none
module sscd_ctrl import sscd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    s_tvalid,
	output logic         s_tready,
	output logic         m_tvalid,
	input  wire logic    m_tready,
	output dp_cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_ACC  = 4'b0100,
		ST_PUSH = 4'b1000
	} state_t;

	state_t state_q;
	op_t    op_q;
	logic   ch_q;
	logic   out_valid_q;
	logic   push;

	assign s_tready = (state_q == ST_IDLE);
	assign push     = (state_q == ST_PUSH) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;

	// Commands to the datapath
	always_comb begin
		cmd.load   = s_tvalid && s_tready;
		cmd.mul_en = (state_q == ST_MUL);
		cmd.acc_en = (state_q == ST_ACC);
		cmd.push   = push;
		cmd.op     = op_q;
		cmd.ch     = ch_q;
	end

	// Step sequencing: one multiply then one accumulate per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_DRIVE;
			ch_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q    <= OP_DRIVE;
						ch_q    <= 1'b0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (op_q == OP_LAST) begin
						op_q <= OP_DRIVE;
						if (ch_q) begin
							state_q <= ST_PUSH;
						end else begin
							ch_q    <= 1'b1;
							state_q <= ST_MUL;
						end
					end else begin
						op_q    <= op_t'(op_q + 4'd1);
						state_q <= ST_MUL;
					end
				end
				ST_PUSH: begin
					if (push) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

@@ src/sscd_dp.sv @@
// Datapath for the stereo soft-clip block: configuration registers, one shared
// multiplier, clipper, biquad state and mix. Driven by sscd_ctrl; uses sscd_pkg.
`default_nettype none
module sscd_dp import sscd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dp_cmd_t              cmd,
	input  wire logic [TDATA_W-1:0]   s_tdata,
	output logic      [TDATA_W-1:0]   m_tdata,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	// Configuration
	logic        [DRIVE_W-1:0]    drive_q;
	logic signed [COEF_WIDTH-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
	logic        [MAKEUP_W-1:0]   makeup_q;
	logic        [MIX_W-1:0]      mix_q;

	// Working registers
	logic signed [SAMPLE_WIDTH-1:0] dry_l_q, dry_r_q;
	logic signed [SAMPLE_WIDTH:0]   x_q;
	logic                           clip_q;
	logic                           neg_q;
	logic        [SAMPLE_WIDTH-1:0] tmp_q;
	logic signed [STATE_W-1:0]      y_q;
	logic signed [PROD_W-1:0]       acc_q;
	logic signed [PROD_W-1:0]       prod_q;
	logic signed [STATE_W-1:0]      d1_q [2];
	logic signed [STATE_W-1:0]      d2_q [2];
	logic signed [SAMPLE_WIDTH-1:0] res_q [2];
	logic        [TDATA_W-1:0]      out_q;

	// Combinational helpers
	logic        [MIX_W-1:0]        mix_eff;
	logic        [MIX_W-1:0]        dry_wt;
	logic signed [SAMPLE_WIDTH-1:0] dry;
	logic signed [MA_W-1:0]         op_a;
	logic signed [MB_W-1:0]         op_b;
	logic signed [PROD_W-1:0]       drv;
	logic signed [PROD_W-1:0]       p_coef;
	logic signed [SAMPLE_WIDTH:0]   cube;
	logic signed [SAMPLE_WIDTH:0]   cube_abs;
	logic        [SAMPLE_WIDTH-1:0] quot;
	logic signed [SAMPLE_WIDTH:0]   x_soft;

	assign m_tdata = out_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q  <= DRIVE_RST;
			b0_q     <= B0_RST;
			b1_q     <= '0;
			b2_q     <= '0;
			a1_q     <= '0;
			a2_q     <= '0;
			makeup_q <= MAKEUP_RST;
			mix_q    <= MIX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DRIVE:  drive_q  <= cfg_data[DRIVE_W-1:0];
				CFG_B0:     b0_q     <= cfg_data[COEF_WIDTH-1:0];
				CFG_B1:     b1_q     <= cfg_data[COEF_WIDTH-1:0];
				CFG_B2:     b2_q     <= cfg_data[COEF_WIDTH-1:0];
				CFG_A1:     a1_q     <= cfg_data[COEF_WIDTH-1:0];
				CFG_A2:     a2_q     <= cfg_data[COEF_WIDTH-1:0];
				CFG_MAKEUP: makeup_q <= cfg_data[MAKEUP_W-1:0];
				CFG_MIX:    mix_q    <= cfg_data[MIX_W-1:0];
				default: ;
			endcase
		end
	end

	// Mix weights, wet share limited to one
	assign mix_eff = (mix_q > MIX_ONE) ? MIX_ONE : mix_q;
	assign dry_wt  = MIX_ONE - mix_eff;
	assign dry     = cmd.ch ? dry_r_q : dry_l_q;

	// Multiplier operand selection
	always_comb begin
		op_a = MA_W'(x_q);
		op_b = MB_W'(x_q);
		case (cmd.op)
			OP_DRIVE: begin
				op_a = MA_W'(dry);
				op_b = MB_W'(drive_q);
			end
			OP_SQ: begin
				op_a = MA_W'(x_q);
				op_b = MB_W'(x_q);
			end
			OP_CUBE: begin
				op_a = MA_W'(x_q);
				op_b = MB_W'(tmp_q);
			end
			OP_DIV3: begin
				op_a = MA_W'(tmp_q);
				op_b = MB_W'(RECIP3);
			end
			OP_B0: begin
				op_a = MA_W'(x_q);
				op_b = MB_W'(b0_q);
			end
			OP_B1: begin
				op_a = MA_W'(x_q);
				op_b = MB_W'(b1_q);
			end
			OP_A1: begin
				op_a = MA_W'(y_q);
				op_b = MB_W'(a1_q);
			end
			OP_B2: begin
				op_a = MA_W'(x_q);
				op_b = MB_W'(b2_q);
			end
			OP_A2: begin
				op_a = MA_W'(y_q);
				op_b = MB_W'(a2_q);
			end
			OP_MAKEUP: begin
				op_a = MA_W'(y_q);
				op_b = MB_W'(makeup_q);
			end
			OP_DRY: begin
				op_a = MA_W'(dry);
				op_b = MB_W'(dry_wt);
			end
			OP_WET: begin
				op_a = MA_W'(y_q);
				op_b = MB_W'(mix_eff);
			end
			default: ;
		endcase
	end

	// Shared multiplier, product registered
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
		end
	end

	// Product views used by the accumulate step
	assign drv      = prod_q >>> GAIN_FRAC;
	assign p_coef   = prod_q >>> COEF_FRAC;
	assign cube     = prod_q[FRAC_BITS +: SAMPLE_WIDTH + 1];
	assign cube_abs = cube[SAMPLE_WIDTH] ? -cube : cube;
	assign quot     = prod_q[SAMPLE_WIDTH + 1 +: SAMPLE_WIDTH];
	assign x_soft   = neg_q ? (x_q + (SAMPLE_WIDTH + 1)'(quot))
	                        : (x_q - (SAMPLE_WIDTH + 1)'(quot));

	// Input capture, per-step accumulate and output word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dry_l_q <= s_tdata[SAMPLE_WIDTH-1:0];
			dry_r_q <= s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
		end
		if (cmd.acc_en) begin
			case (cmd.op)
				OP_DRIVE: begin
					// hard limit beyond unity, else keep the driven sample
					clip_q <= (drv > ONE_P) || (drv < NEG_ONE_P);
					if (drv > ONE_P) begin
						x_q <= CLIP_LIM;
					end else if (drv < NEG_ONE_P) begin
						x_q <= -CLIP_LIM;
					end else begin
						x_q <= drv[SAMPLE_WIDTH:0];
					end
				end
				OP_SQ: begin
					tmp_q <= prod_q[FRAC_BITS +: SAMPLE_WIDTH];
				end
				OP_CUBE: begin
					neg_q <= cube[SAMPLE_WIDTH];
					tmp_q <= cube_abs[SAMPLE_WIDTH-1:0];
				end
				OP_DIV3: begin
					// x - cube/3, quotient truncated toward zero
					if (!clip_q) begin
						x_q <= x_soft;
					end
				end
				OP_B0: begin
					y_q <= sat_state(p_coef + PROD_W'(d1_q[cmd.ch]));
				end
				OP_B1: begin
					acc_q <= p_coef + PROD_W'(d2_q[cmd.ch]);
				end
				OP_B2: begin
					acc_q <= p_coef;
				end
				OP_MAKEUP: begin
					// wet value replaces y from here on
					y_q <= sat_state(prod_q >>> GAIN_FRAC);
				end
				OP_DRY: begin
					acc_q <= prod_q;
				end
				OP_WET: begin
					res_q[cmd.ch] <= sat_sample((acc_q + prod_q) >>> GAIN_FRAC);
				end
				default: ;
			endcase
		end
		if (cmd.push) begin
			out_q <= TDATA_W'({res_q[1], res_q[0]});
		end
	end

	// Biquad delay state, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q[0] <= '0;
			d1_q[1] <= '0;
			d2_q[0] <= '0;
			d2_q[1] <= '0;
		end else if (cmd.acc_en) begin
			if (cmd.op == OP_A1) begin
				d1_q[cmd.ch] <= sat_state(acc_q - p_coef);
			end
			if (cmd.op == OP_A2) begin
				d2_q[cmd.ch] <= sat_state(acc_q - p_coef);
			end
		end
	end

endmodule
`default_nettype wire

@@ src/stereo_soft_clip_distortion_top.sv @@
// Top level of the stereo cubic soft-clip distortion block.
// Instantiates sscd_ctrl and sscd_dp; uses sscd_pkg.
//
// Usage:
// - Slave stream s_*: one stereo frame per word, left and right dry samples.
// - Master stream m_*: one processed stereo frame per input word.
// - cfg_*: plain write port for drive, biquad coefficients, makeup and mix.
//   Write only while no frame is in flight.
// - Each frame runs both channels through one shared multiplier, twelve
//   multiply/accumulate steps per channel, each a multiply state then an
//   accumulate state; a new input word is taken only once the previous
//   frame has been moved to the output register.
// - The output word sits in its own register: the next frame is accepted and
//   processed while the previous result waits; if that result is still not
//   taken when the next one finishes, the block holds until it is.
// - Reset clears the biquad delays, restores the register defaults and
//   empties the output register.
`default_nettype none
module stereo_soft_clip_distortion_top import sscd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [TDATA_W-1:0]   s_tdata,   // left_in, right_in
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [TDATA_W-1:0]   m_tdata,   // left_out, right_out
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	dp_cmd_t cmd;

	// Step sequencer and handshakes
	sscd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// Arithmetic and state
	sscd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
`default_nettype wire

@@ tb/sv/stereo_soft_clip_distortion_top_tb.sv @@
// Self-checking testbench for the stereo cubic soft-clip distortion block.
// Predicts each output word from its own copy of the registers and biquad delays.
// Depends on sscd_pkg and stereo_soft_clip_distortion_top.
`default_nettype none
module stereo_soft_clip_distortion_top_tb;
	import sscd_pkg::*;

	localparam int     CYCLE_LIMIT  = 1000000;
	localparam int     DRAIN_CYCLES = 60;
	localparam int     HOLD_CYCLES  = 800;
	localparam longint MIX_UNITY    = longint'(MIX_ONE);

	localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	typedef struct packed {
		logic [SAMPLE_WIDTH-1:0] right;
		logic [SAMPLE_WIDTH-1:0] left;
	} frame_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata;   // left_in, right_in
	logic                 m_tvalid;
	logic                 m_tready;
	logic [TDATA_W-1:0]   m_tdata;   // left_out, right_out
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// Mirror of the register file and the biquad delays, one pair per channel
	longint drive_gain, makeup_gain, mix_level;
	longint coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
	longint dly_one [2];
	longint dly_two [2];

	frame_t expected_frames [$];

	int idle_pct;
	int stall_pct;
	bit hold_armed;
	int hold_left;
	int cycle_count;
	int frames_sent;
	int frames_checked;
	int settings_loaded;
	int errors;

	stereo_soft_clip_distortion_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d words still awaited", $time, expected_frames.size());
			$display("tb: failure");
			$finish;
		end
	end

	// Output side: random stalls, plus one long hold-off when armed
	always @(negedge clk) begin
		if (hold_armed) begin
			hold_left = HOLD_CYCLES;
			hold_armed = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Compare every accepted output word with the oldest prediction
	always @(posedge clk) begin : check_output
		frame_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_frames.size() == 0) begin
				$display("%0t: unexpected output word %h", $time, m_tdata);
				errors++;
			end else begin
				want = expected_frames.pop_front();
				frames_checked++;
				if (m_tdata[SAMPLE_WIDTH-1:0] !== want.left) begin
					$display("%0t: left_out expected %h, got %h", $time, want.left,
						m_tdata[SAMPLE_WIDTH-1:0]);
					errors++;
				end
				if (m_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] !== want.right) begin
					$display("%0t: right_out expected %h, got %h", $time, want.right,
						m_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);
					errors++;
				end
			end
		end
	end

	function automatic longint clamp_signed(input longint v, input int w);
		longint hi;
		hi = (longint'(1) <<< (w - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	// Cubic clipper x - x^3/3, flat at +-2/3 beyond unity
	function automatic longint cubic_clip(input longint x);
		longint unity, lim, sq, cube;
		unity = longint'(1) <<< FRAC_BITS;
		lim = (longint'(1) <<< (FRAC_BITS + 1)) / 3;
		if (x > unity) return lim;
		if (x < -unity) return -lim;
		sq = (x * x) >>> FRAC_BITS;
		cube = (x * sq) >>> FRAC_BITS;
		return x - cube / 3;
	endfunction

	// Drive, clip, biquad, makeup and dry/wet blend for one channel
	function automatic longint shape_channel(input int ch, input longint dry);
		longint driven, x, y, wet, m;
		driven = (dry * drive_gain) >>> GAIN_FRAC;
		x = cubic_clip(driven);
		y = clamp_signed(((coef_b0 * x) >>> COEF_FRAC) + dly_one[ch], STATE_W);
		dly_one[ch] = clamp_signed(((coef_b1 * x) >>> COEF_FRAC)
			- ((coef_a1 * y) >>> COEF_FRAC) + dly_two[ch], STATE_W);
		dly_two[ch] = clamp_signed(((coef_b2 * x) >>> COEF_FRAC)
			- ((coef_a2 * y) >>> COEF_FRAC), STATE_W);
		wet = clamp_signed((y * makeup_gain) >>> GAIN_FRAC, STATE_W);
		m = (mix_level > MIX_UNITY) ? MIX_UNITY : mix_level;
		return clamp_signed((dry * (MIX_UNITY - m) + wet * m) >>> GAIN_FRAC, SAMPLE_WIDTH);
	endfunction

	// Offer one stereo word, predict its result once it is taken.
	// Entered and left at a falling edge; valid stays high for a following word.
	task automatic send_frame(input logic signed [SAMPLE_WIDTH-1:0] l,
		input logic signed [SAMPLE_WIDTH-1:0] r);
		frame_t f;
		longint lo, ro;
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= TDATA_W'({r, l});
		do @(posedge clk); while (!s_tready);
		lo = shape_channel(0, longint'(l));
		ro = shape_channel(1, longint'(r));
		f.left = lo[SAMPLE_WIDTH-1:0];
		f.right = ro[SAMPLE_WIDTH-1:0];
		expected_frames.push_back(f);
		frames_sent++;
		@(negedge clk);
	endtask

	// Stop offering words and let the pipeline empty completely
	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_frames.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		logic signed [COEF_WIDTH-1:0] cv;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cv = val[COEF_WIDTH-1:0];
		case (idx)
			CFG_DRIVE:  drive_gain = longint'(val[DRIVE_W-1:0]);
			CFG_B0:     coef_b0 = cv;
			CFG_B1:     coef_b1 = cv;
			CFG_B2:     coef_b2 = cv;
			CFG_A1:     coef_a1 = cv;
			CFG_A2:     coef_a2 = cv;
			CFG_MAKEUP: makeup_gain = longint'(val[MAKEUP_W-1:0]);
			CFG_MIX:    mix_level = longint'(val[MIX_W-1:0]);
			default:    ;
		endcase
	endtask

	// Rewrites every register; only called once the block has drained
	task automatic load_settings(input logic [CFG_W-1:0] drv, input logic [CFG_W-1:0] b0,
		input logic [CFG_W-1:0] b1, input logic [CFG_W-1:0] b2,
		input logic [CFG_W-1:0] a1, input logic [CFG_W-1:0] a2,
		input logic [CFG_W-1:0] mk, input logic [CFG_W-1:0] mx);
		write_reg(CFG_DRIVE, drv);
		write_reg(CFG_B0, b0);
		write_reg(CFG_B1, b1);
		write_reg(CFG_B2, b2);
		write_reg(CFG_A1, a1);
		write_reg(CFG_A2, a2);
		write_reg(CFG_MAKEUP, mk);
		write_reg(CFG_MIX, mx);
		cfg_we <= 1'b0;
		settings_loaded++;
	endtask

	// Either a tame stable filter with moderate gains, or raw random register bits
	task automatic random_settings(input bit wild);
		int unit;
		unit = 1 << COEF_FRAC;
		if (wild) begin
			load_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom);
		end else begin
			load_settings($urandom_range(8 << GAIN_FRAC),
				$urandom_range(2 * unit) - unit,
				$urandom_range(2 * unit) - unit,
				$urandom_range(2 * unit) - unit,
				$urandom_range(unit * 9 / 10) - unit * 9 / 20,
				$urandom_range(unit) - unit / 2,
				$urandom_range(3 << GAIN_FRAC),
				$urandom_range(MIX_UNITY));
		end
	endtask

	// Mostly full-range noise, some quiet passages, some rail values
	function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
		int sel;
		sel = $urandom_range(99);
		if (sel < 60) return $urandom;
		if (sel < 85) return $urandom_range(1 << 21) - (1 << 20);
		case ($urandom_range(4))
			0:       return SMP_MAX;
			1:       return SMP_MIN;
			2:       return '0;
			3:       return -1;
			default: return 1;
		endcase
	endfunction

	// Register defaults straight after reset: unity drive, pass-through filter, half mix
	task automatic test_default_settings();
		send_frame(0, 0);
		send_frame(SMP_MAX, SMP_MIN);
		send_frame(SMP_MIN, SMP_MAX);
		send_frame(-1, 1);
		send_frame(1 << 22, -(1 << 22));
		send_frame(24'sh123456, -24'sh345678);
	endtask

	// Clipper knee exactly at unity and just past it, then drive at both rails
	task automatic test_clip_edges();
		drain();
		load_settings(2 << GAIN_FRAC, B0_RST, 0, 0, 0, 0, MAKEUP_RST, MIX_ONE);
		send_frame(1 << 22, -(1 << 22));
		send_frame((1 << 22) + 1, -(1 << 22) - 1);
		send_frame((1 << 22) - 1, -(1 << 22) + 1);
		send_frame(SMP_MAX, SMP_MIN);
		send_frame(0, -1);
		drain();
		load_settings({CFG_W{1'b1}}, B0_RST, 0, 0, 0, 0, MAKEUP_RST, MIX_ONE);
		send_frame(1, -1);
		send_frame(SMP_MAX, SMP_MIN);
		drain();
		load_settings(0, B0_RST, 0, 0, 0, 0, MAKEUP_RST, MIX_ONE);
		send_frame(SMP_MAX, SMP_MIN);
	endtask

	// Extreme coefficients and makeup push the delays and filter output into saturation
	task automatic test_filter_saturation();
		drain();
		load_settings(4 << GAIN_FRAC, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000,
			24'h800000, 24'h03FFFF, MIX_ONE);
		send_frame(SMP_MAX, SMP_MIN);
		send_frame(SMP_MIN, SMP_MAX);
		send_frame(SMP_MAX, SMP_MIN);
		send_frame(SMP_MAX, SMP_MAX);
		send_frame(SMP_MIN, SMP_MIN);
		send_frame(0, 0);
	endtask

	// Mix beyond fully wet, junk above the register widths, and fully dry
	task automatic test_mix_over_unity();
		drain();
		load_settings(65536, B0_RST, 0, 0, 0, 0, 24'hFF0000, 24'hFFFFFF);
		send_frame(24'sh300000, -24'sh300000);
		send_frame(SMP_MAX, SMP_MIN);
		drain();
		load_settings(65536, B0_RST, 0, 0, 0, 0, MAKEUP_RST, 24'h010001);
		send_frame(24'sh200000, -24'sh200000);
		drain();
		load_settings(65536, 24'h7FFFFF, 0, 0, 0, 0, 24'h03FFFF, 0);
		send_frame(SMP_MAX, SMP_MIN);
		send_frame(-24'sh0ABCDE, 24'sh0ABCDE);
	endtask

	// Random words under one idling pattern, new settings every 80 words
	task automatic run_random_phase(input int idle, input int stall, input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 80 == 0) begin
				drain();
				random_settings((i / 80) % 4 == 3);
				idle_pct = idle;
				stall_pct = stall;
			end
			send_frame(pick_sample(), pick_sample());
		end
	endtask

	// Output held off for a long stretch while input words keep coming
	task automatic test_backpressure();
		drain();
		random_settings(1'b0);
		idle_pct = 0;
		stall_pct = 0;
		@(posedge clk);
		hold_armed = 1'b1;
		@(negedge clk);
		for (int i = 0; i < 40; i++) send_frame(pick_sample(), pick_sample());
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_armed = 1'b0;
		hold_left = 0;
		cycle_count = 0;
		frames_sent = 0;
		frames_checked = 0;
		settings_loaded = 0;
		errors = 0;

		// Predictor state as it stands after reset
		drive_gain = longint'(DRIVE_RST);
		coef_b0 = longint'(B0_RST);
		coef_b1 = 0;
		coef_b2 = 0;
		coef_a1 = 0;
		coef_a2 = 0;
		makeup_gain = longint'(MAKEUP_RST);
		mix_level = longint'(MIX_RST);
		for (int c = 0; c < 2; c++) begin
			dly_one[c] = 0;
			dly_two[c] = 0;
		end

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_default_settings();
		test_clip_edges();
		test_filter_saturation();
		test_mix_over_unity();
		run_random_phase(0, 0, 310);
		run_random_phase(53, 0, 310);
		run_random_phase(0, 53, 310);
		run_random_phase(18, 18, 310);
		test_backpressure();
		drain();

		if (expected_frames.size() != 0) begin
			$display("%0t: %0d expected words never arrived", $time, expected_frames.size());
			errors++;
		end
		$display("Checked %0d of %0d stereo words over %0d register settings,",
			frames_checked, frames_sent, settings_loaded);
		$display("with clip knees, filter saturation, mix limits and a long output hold-off.");
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d mismatches", errors);
			$display("tb: failure");
		end
		$finish;
	end

endmodule
`default_nettype wire
